[rtl/core/gqi_pkg.sv]
// shared types, constants and rounding helpers for the gyro quaternion integrator
`timescale 1ns / 1ps

package gqi_pkg;

    // quaternion word: Q2.30
    localparam int QW      = 32;
    localparam int QFRAC   = QW - 2;
    localparam int W_SHIFT = 48 - QFRAC;   // rate * step is Q.48
    localparam int D_SHIFT = QFRAC + 1;    // raw update is Q.(2F+1)

    localparam logic signed [QW-1:0] QONE = QW'(64'd1 << QFRAC);
    localparam logic signed [QW-1:0] QLIM = QW'((64'd1 << (QW - 1)) - 64'd1);

    localparam logic [31:0] STEP_RESET = 32'd42949673;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic [47:0]        sample_time;
        logic [47:0]        window_start;
        logic [47:0]        window_end;
    } gqi_in_t;

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic                 applied;
    } gqi_out_t;

    // control into the divide / root unit
    typedef struct packed {
        logic start;
        logic div;
    } dsu_ctl_t;

    // one product term of q (x) (0, w)
    typedef struct packed {
        logic [1:0] qi;
        logic [1:0] wi;
        logic [1:0] tgt;
        logic       neg;
    } qop_t;

    function automatic qop_t qop(input logic [3:0] idx);
        qop_t r;
        r = '0;
        unique case (idx)
            4'd0:    r = '{qi: 2'd1, wi: 2'd0, tgt: 2'd0, neg: 1'b1};
            4'd1:    r = '{qi: 2'd2, wi: 2'd1, tgt: 2'd0, neg: 1'b1};
            4'd2:    r = '{qi: 2'd3, wi: 2'd2, tgt: 2'd0, neg: 1'b1};
            4'd3:    r = '{qi: 2'd0, wi: 2'd0, tgt: 2'd1, neg: 1'b0};
            4'd4:    r = '{qi: 2'd3, wi: 2'd1, tgt: 2'd1, neg: 1'b1};
            4'd5:    r = '{qi: 2'd2, wi: 2'd2, tgt: 2'd1, neg: 1'b0};
            4'd6:    r = '{qi: 2'd3, wi: 2'd0, tgt: 2'd2, neg: 1'b0};
            4'd7:    r = '{qi: 2'd0, wi: 2'd1, tgt: 2'd2, neg: 1'b0};
            4'd8:    r = '{qi: 2'd1, wi: 2'd2, tgt: 2'd2, neg: 1'b1};
            4'd9:    r = '{qi: 2'd1, wi: 2'd1, tgt: 2'd3, neg: 1'b0};
            4'd10:   r = '{qi: 2'd0, wi: 2'd2, tgt: 2'd3, neg: 1'b0};
            4'd11:   r = '{qi: 2'd2, wi: 2'd0, tgt: 2'd3, neg: 1'b1};
            default: r = '0;
        endcase
        return r;
    endfunction

    // shift right rounding half away from zero, then symmetric saturation
    function automatic logic signed [QW-1:0] rnd_sat(input logic signed [65:0] v,
                                                      input int unsigned sh);
        logic [65:0] m;
        logic [65:0] r;
        m = v[65] ? 66'(-v) : 66'(v);
        r = (m + (66'd1 << (sh - 1))) >> sh;
        if (r > 66'(QLIM)) r = 66'(QLIM);
        return v[65] ? -(QW'(r)) : QW'(r);
    endfunction

endpackage

[rtl/core/gyro_quaternion_integrator.sv]
// top level: sequencer, attitude state and result register of the gyro integrator
// a sample inside the window runs the full update, a sample outside it goes straight to the
//   result stage; one sample at a time, so a new sample is stalled until the last one is done
// the update is dominated by the bit-serial root (32 steps) and four divides (31 steps each)
//   on the shared divide / root unit, plus 19 passes through the shared multiplier
// reset: attitude returns to identity, step time to 0.01 s, no result pending
`timescale 1ns / 1ps

module gyro_quaternion_integrator (
    input  logic             clk,
    input  logic             rst_n,
    // sample channel
    input  logic             in_valid,
    output logic             in_stall,
    input  gqi_pkg::gqi_in_t in_data,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output gqi_pkg::gqi_out_t out_data,
    // step time register
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WMUL  = 3'd1;   // angle increments
    localparam logic [2:0] ST_QMUL  = 3'd2;   // quaternion product terms
    localparam logic [2:0] ST_SQMUL = 3'd3;   // squares for the norm
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;   // one divide per component
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam int QW = gqi_pkg::QW;

    logic [2:0]  state_reg;
    logic [3:0]  cnt_reg;
    logic        pend_reg;       // root or divide launched, waiting for done
    logic        out_valid_reg;
    logic        applied_reg;
    logic [31:0] step_reg;

    logic signed [QW-1:0] q_reg [4];      // kept attitude w, x, y, z
    logic signed [31:0]   rate_reg [3];
    logic signed [QW-1:0] w_reg [3];      // angle increments
    logic signed [63:0]   acc_reg [4];    // raw update accumulators
    logic signed [QW-1:0] d_reg [4];      // reduced update
    logic [63:0]          sum_reg;        // sum of squares
    logic [31:0]          n_reg;          // norm
    gqi_pkg::gqi_out_t    out_reg;

    logic                 in_win;
    logic                 in_beat;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   prod;
    gqi_pkg::qop_t        op_issue;
    gqi_pkg::qop_t        op_done;
    logic [1:0]           sq_idx;
    logic [1:0]           k;
    logic [31:0]          dmag;
    logic [63:0]          div_n;
    logic [31:0]          qmag;
    logic signed [QW-1:0] q_new;

    gqi_pkg::dsu_ctl_t    dsu_ctl;
    logic [63:0]          dsu_opa;
    logic                 dsu_done;
    logic [31:0]          dsu_res;

    // inclusive window at both ends; an inverted window holds nothing
    assign in_win  = (in_data.sample_time >= in_data.window_start) &&
                     (in_data.sample_time <= in_data.window_end);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_beat  = in_valid && !in_stall;

    assign op_issue = gqi_pkg::qop(cnt_reg);
    assign op_done  = gqi_pkg::qop(cnt_reg - 4'd1);
    assign sq_idx   = 2'(cnt_reg - 4'd1);
    assign k        = cnt_reg[1:0];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_WMUL:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:    mul_a = 33'(rate_reg[0]);
                    2'd1:    mul_a = 33'(rate_reg[1]);
                    default: mul_a = 33'(rate_reg[2]);
                endcase
                mul_b = {1'b0, step_reg};
            end
            ST_QMUL:
            begin
                mul_a = 33'(q_reg[op_issue.qi]);
                unique case (op_issue.wi)
                    2'd0:    mul_b = 33'(w_reg[0]);
                    2'd1:    mul_b = 33'(w_reg[1]);
                    default: mul_b = 33'(w_reg[2]);
                endcase
            end
            ST_SQMUL:
            begin
                mul_a = 33'(d_reg[sq_idx]);
                mul_b = 33'(d_reg[sq_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gqi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // dividend: |d| * 2^F plus half the norm, for rounding half away from zero
    assign dmag  = d_reg[k][QW-1] ? 32'(-d_reg[k]) : 32'(d_reg[k]);
    assign div_n = ({32'd0, dmag} << gqi_pkg::QFRAC) + {33'd0, n_reg[31:1]};

    assign dsu_ctl.start = ((state_reg == ST_SQRT) || (state_reg == ST_DIV)) && !pend_reg;
    assign dsu_ctl.div   = (state_reg == ST_DIV);
    assign dsu_opa       = (state_reg == ST_DIV) ? div_n : sum_reg;

    gqi_dsu u_dsu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dsu_ctl),
        .opa    (dsu_opa),
        .den    (n_reg),
        .done   (dsu_done),
        .result (dsu_res)
    );

    // clamp the quotient to one and put the sign back
    assign qmag  = (dsu_res > 32'(gqi_pkg::QONE)) ? 32'(gqi_pkg::QONE) : dsu_res;
    assign q_new = d_reg[k][QW-1] ? -(QW'(qmag)) : QW'(qmag);

    // control, configuration and attitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            applied_reg   <= 1'b0;
            step_reg      <= gqi_pkg::STEP_RESET;
            q_reg[0]      <= gqi_pkg::QONE;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
        end
        else
        begin
            if (cfg_we) step_reg <= cfg_wdata;
            // the result stage handles its own valid
            if (out_valid_reg && !out_stall && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        applied_reg <= in_win;
                        cnt_reg     <= '0;
                        state_reg   <= in_win ? ST_WMUL : ST_OUT;
                    end
                end
                ST_WMUL:
                begin
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_QMUL;
                    end
                    else cnt_reg <= cnt_reg + 4'd1;
                end
                ST_QMUL:
                begin
                    if (cnt_reg == 4'd12)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQMUL;
                    end
                    else cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SQMUL:
                begin
                    if (cnt_reg == 4'd5)
                    begin
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_SQRT;
                    end
                    else cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SQRT:
                begin
                    if (!pend_reg) pend_reg <= 1'b1;
                    else if (dsu_done)
                    begin
                        pend_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (!pend_reg) pend_reg <= 1'b1;
                    else if (dsu_done)
                    begin
                        // zero norm leaves the attitude as it was
                        if (n_reg != '0) q_reg[k] <= q_new;
                        pend_reg <= 1'b0;
                        if (cnt_reg == 4'd3) state_reg <= ST_OUT;
                        else cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            rate_reg[0] <= in_data.rate_x;
            rate_reg[1] <= in_data.rate_y;
            rate_reg[2] <= in_data.rate_z;
        end

        if (state_reg == ST_WMUL)
        begin
            unique case (cnt_reg)
                4'd1:    w_reg[0] <= gqi_pkg::rnd_sat(prod, gqi_pkg::W_SHIFT);
                4'd2:    w_reg[1] <= gqi_pkg::rnd_sat(prod, gqi_pkg::W_SHIFT);
                4'd3:    w_reg[2] <= gqi_pkg::rnd_sat(prod, gqi_pkg::W_SHIFT);
                default: ;
            endcase
            // raw update starts from q at Q.(2F+1)
            if (cnt_reg == 4'd3)
            begin
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= 64'(q_reg[i]) <<< gqi_pkg::D_SHIFT;
            end
        end

        if ((state_reg == ST_QMUL) && (cnt_reg != '0))
        begin
            if (op_done.neg)
                acc_reg[op_done.tgt] <= acc_reg[op_done.tgt] - prod[63:0];
            else
                acc_reg[op_done.tgt] <= acc_reg[op_done.tgt] + prod[63:0];
        end

        if (state_reg == ST_SQMUL)
        begin
            if (cnt_reg == '0)
            begin
                for (int i = 0; i < 4; i++)
                    d_reg[i] <= gqi_pkg::rnd_sat(66'(acc_reg[i]), gqi_pkg::D_SHIFT);
                sum_reg <= '0;
            end
            else if (cnt_reg >= 4'd2)
                sum_reg <= sum_reg + prod[63:0];
        end

        if ((state_reg == ST_SQRT) && pend_reg && dsu_done) n_reg <= dsu_res;

        if ((state_reg == ST_OUT) && (!out_valid_reg || !out_stall))
        begin
            out_reg.quat_w  <= q_reg[0];
            out_reg.quat_x  <= q_reg[1];
            out_reg.quat_y  <= q_reg[2];
            out_reg.quat_z  <= q_reg[3];
            out_reg.applied <= applied_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // attitude stays within unit magnitude per component
    a_att_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_reg[0] <= gqi_pkg::QONE) && (q_reg[0] >= -gqi_pkg::QONE) &&
        (q_reg[1] <= gqi_pkg::QONE) && (q_reg[1] >= -gqi_pkg::QONE) &&
        (q_reg[2] <= gqi_pkg::QONE) && (q_reg[2] >= -gqi_pkg::QONE) &&
        (q_reg[3] <= gqi_pkg::QONE) && (q_reg[3] >= -gqi_pkg::QONE))
        else $error("attitude component beyond one");

    // a sample outside its window goes straight to the result stage
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !in_win) |=> (state_reg == ST_OUT) && !applied_reg)
        else $error("out-of-window sample not bypassed");

    // divide / root unit only finishes while the sequencer waits for it
    a_dsu_done: assert property (@(posedge clk) disable iff (!rst_n)
        dsu_done |-> ((state_reg == ST_SQRT) || (state_reg == ST_DIV)) && pend_reg)
        else $error("divide/root done outside its phase");

    // a new result beat only comes from the result stage
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result beat raised outside result stage");

endmodule

[rtl/core/gqi_mul.sv]
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module gqi_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 66'(a) * 66'(b);
    end

    assign p = p_reg;

endmodule

[rtl/core/gqi_dsu.sv]
// bit-serial unit for integer square root and fractional divide
`timescale 1ns / 1ps

module gqi_dsu (
    input  logic              clk,
    input  logic              rst_n,
    input  gqi_pkg::dsu_ctl_t ctl,
    input  logic [63:0]       opa,
    input  logic [31:0]       den,
    output logic              done,
    output logic [31:0]       result
);

    logic        busy_reg;
    logic        div_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] x_reg;
    logic [31:0] den_reg;
    logic        ovf_reg;

    logic [34:0] cand;
    logic [34:0] trial;
    logic        ge;

    // shared compare / subtract
    always_comb
    begin
        if (div_reg)
        begin
            cand  = {2'b00, rem_reg[31:0], x_reg[63]};
            trial = {3'b000, den_reg};
        end
        else
        begin
            // root remainder runs up to twice the partial root
            cand  = {rem_reg[32:0], x_reg[63:62]};
            trial = {1'b0, root_reg, 2'b01};
        end
        ge = (cand >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.div ? 6'd31 : 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            div_reg  <= ctl.div;
            den_reg  <= den;
            root_reg <= '0;
            if (ctl.div)
            begin
                // upper part at or above the divisor: quotient at or above 2^31
                rem_reg <= {3'b000, opa[61:31]};
                x_reg   <= {opa[30:0], 33'd0};
                ovf_reg <= (opa[63:31] >= {1'b0, den});
            end
            else
            begin
                rem_reg <= '0;
                x_reg   <= opa;
                ovf_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= 34'(ge ? (cand - trial) : cand);
            root_reg <= {root_reg[30:0], ge};
            x_reg    <= div_reg ? {x_reg[62:0], 1'b0} : {x_reg[61:0], 2'b00};
        end
    end

    assign done   = done_reg;
    assign result = ovf_reg ? '1 : root_reg;

endmodule
